FILE: rtl/sorted_priority_queue_top_assert.svh
// ---------------------------------------------------------------------------
// sorted_priority_queue_top_assert.svh
// Assertion macros for the sorted priority queue. Simulation builds get
// concurrent assertions; synthesis builds get empty bodies.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SPQ_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: field widths,
// opcodes, status codes, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	// field widths
	localparam int unsigned PRIO_W   = 16;
	localparam int unsigned ITEM_W   = 32;
	localparam int unsigned ENTRY_W  = PRIO_W + ITEM_W;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W    = 7;

	// opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_DELETED   = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEL_WAIT,
		ST_INS_SCAN,
		ST_INS_LAST,
		ST_RESULT
	} state_t;

	// logical read index select
	typedef enum logic [1:0] {
		RD_HEAD,
		RD_TAIL,
		RD_PREV
	} rd_sel_t;

	// logical write index select
	typedef enum logic {
		WR_AT_NEXT,
		WR_AT_ZERO
	} wr_at_t;

	// write data select
	typedef enum logic {
		WD_SHIFT,
		WD_NEW
	} wd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    ld_in;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    k_ld;
		logic    k_dec;
		logic    wr_en;
		wr_at_t  wr_at;
		wd_sel_t wd_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    head_inc;
		logic    res_ld;
		status_t res_status;
		logic    res_item;
		logic    out_ld;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic prio_gt;
		logic k_zero;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/spq_ram.sv
// ---------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/spq_dpath.sv
// ---------------------------------------------------------------------------
// spq_dpath
// Datapath of the sorted priority queue: circular entry store, head and
// count registers, scan index, insert operand latch and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_dpath #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire spq_pkg::cmd_t                        cmd,
	output spq_pkg::sts_t                             sts,
	input  wire logic signed [spq_pkg::ITEM_W-1:0]    item_value,
	input  wire logic signed [spq_pkg::PRIO_W-1:0]    entry_priority_in,
	output logic             [spq_pkg::STATUS_W-1:0]  status,
	output logic signed      [spq_pkg::ITEM_W-1:0]    removed_item,
	output logic             [spq_pkg::OCC_W-1:0]     occupancy
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_A = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] k_q;
	logic signed [spq_pkg::PRIO_W-1:0] prio_q;
	logic        [spq_pkg::ITEM_W-1:0] item_q;

	spq_pkg::status_t           res_status_q;
	logic [spq_pkg::ITEM_W-1:0] res_item_q;

	logic [AW-1:0] tail_idx;
	logic [AW-1:0] rd_log;
	logic [AW-1:0] wr_log;
	logic [AW:0]   rd_sum;
	logic [AW:0]   wr_sum;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [spq_pkg::ENTRY_W-1:0] wr_data;
	logic [spq_pkg::ENTRY_W-1:0] rd_data;
	logic signed [spq_pkg::PRIO_W-1:0] rd_prio;
	logic        [spq_pkg::ITEM_W-1:0] rd_item;

	assign tail_idx = AW'(count_q - CW'(1));
	assign rd_prio  = rd_data[spq_pkg::ENTRY_W-1:spq_pkg::ITEM_W];
	assign rd_item  = rd_data[spq_pkg::ITEM_W-1:0];

	// logical read index
	always_comb begin
		case (cmd.rd_sel)
			spq_pkg::RD_HEAD: rd_log = '0;
			spq_pkg::RD_TAIL: rd_log = tail_idx;
			spq_pkg::RD_PREV: rd_log = k_q - AW'(1);
			default:          rd_log = '0;
		endcase
	end

	// logical write index and data
	always_comb begin
		case (cmd.wr_at)
			spq_pkg::WR_AT_NEXT: wr_log = k_q + AW'(1);
			spq_pkg::WR_AT_ZERO: wr_log = '0;
			default:             wr_log = '0;
		endcase
		case (cmd.wd_sel)
			spq_pkg::WD_SHIFT: wr_data = rd_data;
			spq_pkg::WD_NEW:   wr_data = {prio_q, item_q};
			default:           wr_data = rd_data;
		endcase
	end

	// logical to physical: head offset, wrap at capacity
	always_comb begin
		rd_sum = {1'b0, head_q} + {1'b0, rd_log};
		wr_sum = {1'b0, head_q} + {1'b0, wr_log};
		rd_addr = (rd_sum >= CAP_A) ? AW'(rd_sum - CAP_A) : AW'(rd_sum);
		wr_addr = (wr_sum >= CAP_A) ? AW'(wr_sum - CAP_A) : AW'(wr_sum);
	end

	spq_ram #(
		.WIDTH (spq_pkg::ENTRY_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// occupancy and head pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.head_inc) begin
				head_q <= (head_q == LAST_A) ? '0 : head_q + AW'(1);
			end
		end
	end

	// scan index, insert operands, results
	always_ff @(posedge clk) begin
		if (cmd.k_ld) begin
			k_q <= tail_idx;
		end else if (cmd.k_dec) begin
			k_q <= k_q - AW'(1);
		end
		if (cmd.ld_in) begin
			prio_q <= entry_priority_in;
			item_q <= item_value;
		end
		if (cmd.res_ld) begin
			res_status_q <= cmd.res_status;
			res_item_q   <= cmd.res_item ? rd_item : '0;
		end
		if (cmd.out_ld) begin
			status       <= res_status_q;
			removed_item <= res_item_q;
			occupancy    <= spq_pkg::OCC_W'(count_q);
		end
	end

	// status to controller
	assign sts.empty   = (count_q == '0);
	assign sts.full    = (count_q == CAP_C);
	assign sts.prio_gt = (rd_prio > prio_q);
	assign sts.k_zero  = (k_q == '0);

endmodule

`default_nettype wire

FILE: rtl/spq_ctrl.sv
// ---------------------------------------------------------------------------
// spq_ctrl
// Controller of the sorted priority queue: input handshake, operation
// sequencing (head read, tail-to-head insertion scan) and output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          opcode,
	output logic               out_valid,
	input  wire logic          out_stall,
	output spq_pkg::cmd_t      cmd,
	input  wire spq_pkg::sts_t sts
);

	spq_pkg::state_t state_q;
	spq_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            slot_free;

	assign in_stall  = (state_q != spq_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.rd_sel     = spq_pkg::RD_HEAD;
		cmd.wr_at      = spq_pkg::WR_AT_NEXT;
		cmd.wd_sel     = spq_pkg::WD_SHIFT;
		cmd.res_status = spq_pkg::STAT_INSERTED;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					if (opcode == spq_pkg::OP_DELETE) begin
						if (sts.empty) begin
							cmd.res_ld     = 1'b1;
							cmd.res_status = spq_pkg::STAT_UNDERFLOW;
							state_nxt      = spq_pkg::ST_RESULT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = spq_pkg::RD_HEAD;
							state_nxt  = spq_pkg::ST_DEL_WAIT;
						end
					end else if (sts.full) begin
						cmd.res_ld     = 1'b1;
						cmd.res_status = spq_pkg::STAT_FULL;
						state_nxt      = spq_pkg::ST_RESULT;
					end else if (sts.empty) begin
						state_nxt = spq_pkg::ST_INS_LAST;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = spq_pkg::RD_TAIL;
						cmd.k_ld   = 1'b1;
						state_nxt  = spq_pkg::ST_INS_SCAN;
					end
				end
			end
			// head entry arrives from the store
			spq_pkg::ST_DEL_WAIT: begin
				cmd.res_ld     = 1'b1;
				cmd.res_status = spq_pkg::STAT_DELETED;
				cmd.res_item   = 1'b1;
				cmd.head_inc   = 1'b1;
				cmd.cnt_dec    = 1'b1;
				state_nxt      = spq_pkg::ST_RESULT;
			end
			// walk from the tail, moving larger priorities up one slot
			spq_pkg::ST_INS_SCAN: begin
				cmd.wr_en = 1'b1;
				cmd.wr_at = spq_pkg::WR_AT_NEXT;
				if (sts.prio_gt) begin
					cmd.wd_sel = spq_pkg::WD_SHIFT;
					if (sts.k_zero) begin
						state_nxt = spq_pkg::ST_INS_LAST;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = spq_pkg::RD_PREV;
						cmd.k_dec  = 1'b1;
					end
				end else begin
					cmd.wd_sel     = spq_pkg::WD_NEW;
					cmd.cnt_inc    = 1'b1;
					cmd.res_ld     = 1'b1;
					cmd.res_status = spq_pkg::STAT_INSERTED;
					state_nxt      = spq_pkg::ST_RESULT;
				end
			end
			// new entry becomes the head
			spq_pkg::ST_INS_LAST: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_at      = spq_pkg::WR_AT_ZERO;
				cmd.wd_sel     = spq_pkg::WD_NEW;
				cmd.cnt_inc    = 1'b1;
				cmd.res_ld     = 1'b1;
				cmd.res_status = spq_pkg::STAT_INSERTED;
				state_nxt      = spq_pkg::ST_RESULT;
			end
			spq_pkg::ST_RESULT: begin
				if (slot_free) begin
					cmd.out_ld = 1'b1;
					state_nxt  = spq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = spq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue_top.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue of (item, priority) entries kept in ascending
// priority order; equal priorities leave in arrival order.
//
// Input channel (in_valid/in_stall): one word per operation, opcode 0
// inserts (item_value, entry_priority_in), opcode 1 removes the head.
// Output channel (out_valid/out_stall): one word per operation with status,
// removed_item (zero unless a head was removed) and occupancy afterwards.
// An underflow or a full reject goes straight to the result; a delete reads
// the head entry from the store; an insert walks from the tail toward the
// head, one store read and one store write per cycle, past every entry of
// higher priority value, then writes the new entry. One operation is in
// flight at a time; the next word is taken only once the result has been
// loaded onto the output.
// Entries live in a circular single-port-read/single-port-write RAM;
// a delete only moves the head pointer.
// Reset empties the queue at once; the store contents are not cleared.
// While the receiver stalls, the finished word holds on the output and
// the next operation may be accepted and worked up to its own result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                opcode,
	input  wire logic signed [spq_pkg::ITEM_W-1:0]   item_value,
	input  wire logic signed [spq_pkg::PRIO_W-1:0]   entry_priority_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic             [spq_pkg::STATUS_W-1:0] status,
	output logic signed      [spq_pkg::ITEM_W-1:0]   removed_item,
	output logic             [spq_pkg::OCC_W-1:0]    occupancy
);

	spq_pkg::cmd_t cmd;
	spq_pkg::sts_t sts;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	spq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.item_value        (item_value),
		.entry_priority_in (entry_priority_in),
		.status            (status),
		.removed_item      (removed_item),
		.occupancy         (occupancy)
	);

	// checks
	`SPQ_ASSERT_IMPLIES(a_no_inc_full, cmd.cnt_inc, !sts.full, "insert into full store")
	`SPQ_ASSERT_IMPLIES(a_no_dec_empty, cmd.cnt_dec, !sts.empty, "delete from empty store")
	`SPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept while busy")
	`SPQ_ASSERT_IMPLIES(a_removed_zero, out_valid && (status != spq_pkg::STAT_DELETED), removed_item == '0, "removed item not zero")

endmodule

`default_nettype wire

FILE: test/sorted_priority_queue_top_tb.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Self-checking bench for the sorted priority queue. A short table of
// directed words covers empty deletes, extreme items and priorities, and
// ties. Random phases then fill the queue to full and past it, churn it,
// and drain it to underflow. Every accepted word runs through a behavioral
// queue model. Each result word is checked field by field, in order.
// Both handshake sides insert random gaps and stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY     = 64;
	localparam int unsigned RANDOM_WORDS = 1330;
	// worst insert walks the whole store, plus margin
	localparam int unsigned SETTLE_CYCLES = CAPACITY + 16;

	typedef struct {
		spq_pkg::status_t                     st;
		logic signed [spq_pkg::ITEM_W-1:0]    item;
		logic        [spq_pkg::OCC_W-1:0]     occ;
	} pq_result_t;

	typedef struct {
		logic signed [spq_pkg::PRIO_W-1:0]    prio;
		logic signed [spq_pkg::ITEM_W-1:0]    item;
	} pq_entry_t;

	typedef struct {
		logic                                 op;
		logic signed [spq_pkg::ITEM_W-1:0]    item;
		logic signed [spq_pkg::PRIO_W-1:0]    prio;
		bit                                   typed;
		pq_result_t                           want;
	} dir_row_t;

	typedef enum int {
		PH_FILL,
		PH_MIX,
		PH_DRAIN
	} phase_kind_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_stall;
	logic                                 opcode;
	logic signed [spq_pkg::ITEM_W-1:0]    item_value;
	logic signed [spq_pkg::PRIO_W-1:0]    entry_priority_in;
	logic                                 out_valid;
	logic                                 out_stall;
	logic        [spq_pkg::STATUS_W-1:0]  status;
	logic signed [spq_pkg::ITEM_W-1:0]    removed_item;
	logic        [spq_pkg::OCC_W-1:0]     occupancy;

	pq_entry_t   held_entries[$];
	pq_result_t  pending_results[$];
	pq_result_t  arrived_want;
	bit          no_idle = 1'b0;
	int unsigned mismatches = 0;
	int unsigned n_inserted = 0;
	int unsigned n_deleted = 0;
	int unsigned n_underflow = 0;
	int unsigned n_full = 0;
	int unsigned peak_fill = 0;

	// directed words: empty queue, extremes, ties, then model-checked churn
	dir_row_t dir_rows [22] = '{
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b1,
			'{spq_pkg::STAT_UNDERFLOW, 32'sh0, 7'd0}},
		'{spq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 16'sh0000, 1'b1,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd1}},
		'{spq_pkg::OP_INSERT, 32'sh8000_0000, 16'sh7FFF, 1'b1,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd2}},
		'{spq_pkg::OP_INSERT, 32'sh0000_0001, 16'sh8000, 1'b1,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd3}},
		'{spq_pkg::OP_INSERT, 32'shFFFF_FFFF, 16'sh0000, 1'b1,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd4}},
		'{spq_pkg::OP_INSERT, 32'sh0000_0005, 16'sh7FFF, 1'b1,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd5}},
		'{spq_pkg::OP_INSERT, 32'sh0000_0006, 16'sh8000, 1'b1,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd6}},
		'{spq_pkg::OP_DELETE, 32'shFFFF_FFFF, 16'sh7FFF, 1'b1,
			'{spq_pkg::STAT_DELETED, 32'sh0000_0001, 7'd5}},
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b1,
			'{spq_pkg::STAT_DELETED, 32'sh0000_0006, 7'd4}},
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b1,
			'{spq_pkg::STAT_DELETED, 32'sh7FFF_FFFF, 7'd3}},
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b1,
			'{spq_pkg::STAT_DELETED, 32'shFFFF_FFFF, 7'd2}},
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b1,
			'{spq_pkg::STAT_DELETED, 32'sh8000_0000, 7'd1}},
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b1,
			'{spq_pkg::STAT_DELETED, 32'sh0000_0005, 7'd0}},
		'{spq_pkg::OP_DELETE, 32'sh1234_5678, 16'sh8000, 1'b1,
			'{spq_pkg::STAT_UNDERFLOW, 32'sh0, 7'd0}},
		'{spq_pkg::OP_INSERT, 32'sh1234_5678, 16'sh0064, 1'b0,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd0}},
		'{spq_pkg::OP_INSERT, 32'shA5A5_A5A5, 16'shFFFF, 1'b0,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd0}},
		'{spq_pkg::OP_INSERT, 32'sh5A5A_5A5A, 16'sh0001, 1'b0,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd0}},
		'{spq_pkg::OP_DELETE, 32'shFFFF_FFFF, 16'sh7FFF, 1'b0,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd0}},
		'{spq_pkg::OP_INSERT, 32'shDEAD_BEEF, 16'sh0064, 1'b0,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd0}},
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b0,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd0}},
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b0,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd0}},
		'{spq_pkg::OP_DELETE, 32'sh0000_0000, 16'sh0000, 1'b0,
			'{spq_pkg::STAT_INSERTED, 32'sh0, 7'd0}}
	};

	sorted_priority_queue_top #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.item_value       (item_value),
		.entry_priority_in(entry_priority_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.removed_item     (removed_item),
		.occupancy        (occupancy)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// queue behavior: apply one operation, return the result word it yields
	function automatic pq_result_t queue_apply(input logic op,
			input logic signed [spq_pkg::ITEM_W-1:0] item,
			input logic signed [spq_pkg::PRIO_W-1:0] prio);
		pq_result_t res;
		pq_entry_t  ent;
		int         pos;
		res.item = '0;
		if (op == spq_pkg::OP_INSERT) begin
			if (held_entries.size() >= CAPACITY) begin
				res.st = spq_pkg::STAT_FULL;
				n_full++;
			end else begin
				// new entry goes behind every entry of lower or equal priority
				pos = 0;
				while (pos < held_entries.size() && held_entries[pos].prio <= prio)
					pos++;
				ent.prio = prio;
				ent.item = item;
				held_entries.insert(pos, ent);
				res.st = spq_pkg::STAT_INSERTED;
				n_inserted++;
			end
		end else begin
			if (held_entries.size() == 0) begin
				res.st = spq_pkg::STAT_UNDERFLOW;
				n_underflow++;
			end else begin
				ent = held_entries.pop_front();
				res.item = ent.item;
				res.st = spq_pkg::STAT_DELETED;
				n_deleted++;
			end
		end
		if (held_entries.size() > peak_fill)
			peak_fill = held_entries.size();
		res.occ = spq_pkg::OCC_W'(held_entries.size());
		return res;
	endfunction

	// offer one word after a random gap, log its expected result on accept
	task automatic send_word(input logic op, input logic signed [spq_pkg::ITEM_W-1:0] item,
			input logic signed [spq_pkg::PRIO_W-1:0] prio, input bit typed,
			input pq_result_t want);
		int unsigned gap;
		pq_result_t  res;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid          <= 1'b1;
		opcode            <= op;
		item_value        <= item;
		entry_priority_in <= prio;
		do @(posedge clk); while (in_stall);
		res = queue_apply(op, item, prio);
		pending_results.push_back(typed ? want : res);
	endtask

	// hold the sender off until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// priority draw: mostly a narrow band for ties, sometimes full range/extremes
	function automatic logic signed [spq_pkg::PRIO_W-1:0] draw_prio();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return spq_pkg::PRIO_W'($signed($urandom_range(0, 6)) - 3);
		else if (sel < 8)
			return spq_pkg::PRIO_W'($urandom);
		else if (sel == 8)
			return 16'sh8000;
		return 16'sh7FFF;
	endfunction

	// stimulus
	initial begin : stimulus
		phase_kind_t kind;
		int unsigned ins_pct;
		int unsigned len;
		int unsigned sent;
		int unsigned phase_idx;
		pq_result_t  dont_care;
		logic        op;

		arst_n            = 1'b0;
		in_valid          = 1'b0;
		opcode            = spq_pkg::OP_INSERT;
		item_value        = '0;
		entry_priority_in = '0;
		dont_care         = '{spq_pkg::STAT_INSERTED, '0, '0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].item, dir_rows[i].prio,
				dir_rows[i].typed, dir_rows[i].want);
		drain_results();

		// random phases; the first one fills the queue and pushes past full
		sent = 0;
		phase_idx = 0;
		while (sent < RANDOM_WORDS) begin
			kind = (phase_idx == 0) ? PH_FILL : phase_kind_t'($urandom_range(0, 2));
			len  = (phase_idx == 0) ? 90 : $urandom_range(40, 120);
			case (kind)
				PH_FILL:  ins_pct = 92;
				PH_MIX:   ins_pct = 55;
				default:  ins_pct = 12;
			endcase
			no_idle = (phase_idx != 0) && ($urandom_range(0, 3) == 0);
			for (int unsigned j = 0; j < len && sent < RANDOM_WORDS; j++) begin
				op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT
					: spq_pkg::OP_DELETE;
				send_word(op, spq_pkg::ITEM_W'($urandom), draw_prio(), 1'b0, dont_care);
				sent++;
			end
			if (phase_idx == 0 || $urandom_range(0, 2) == 0)
				drain_results();
			phase_idx++;
		end
		no_idle = 1'b0;

		// let everything come back
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d inserts, %0d deletes, %0d underflows, %0d full rejects",
			n_inserted, n_deleted, n_underflow, n_full);
		$display("Peak occupancy %0d of %0d over %0d random phases",
			peak_fill, CAPACITY, phase_idx);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// result side: random stall ahead of each word
	initial begin : result_sink
		int unsigned hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// compare each accepted word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: status %0d item %0d occ %0d",
					status, removed_item, occupancy);
				mismatches++;
			end else begin
				arrived_want = pending_results.pop_front();
				if (status !== arrived_want.st) begin
					$error("status: expected %0d, got %0d", arrived_want.st, status);
					mismatches++;
				end
				if (removed_item !== arrived_want.item) begin
					$error("removed_item: expected %0d, got %0d",
						arrived_want.item, removed_item);
					mismatches++;
				end
				if (occupancy !== arrived_want.occ) begin
					$error("occupancy: expected %0d, got %0d", arrived_want.occ, occupancy);
					mismatches++;
				end
			end
		end
	end

	// hang guard
	initial begin : watchdog
		#6_000_000;
		$display("Timeout: %0d results still outstanding", pending_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
